// ===== hdl/apb_pkg.sv =====
package apb_pkg;

    localparam int CHAN_MAX     = 64;
    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_STRIDE   = 8;
    localparam int MAX_KERNEL   = 16;

    localparam int CH_W      = $clog2(CHAN_MAX);
    localparam int POS_W     = $clog2(MAX_WIDTH);
    localparam int KAW       = $clog2(MAX_KERNEL);
    localparam int ACC_DEPTH = CHAN_MAX * MAX_KERNEL;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);

    // register and field widths
    localparam int CHN_W      = 7;
    localparam int RW_W       = 13;
    localparam int STR_W      = 4;
    localparam int KER_W      = 5;
    localparam int RECIP_W    = 16;
    localparam int GRAD_W     = 32;
    localparam int ACC_W      = 36;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = ACC_W + RECIP_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP     = 3'd4;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 16'h8000;

    // one position on its way from the sequencer to the accumulator stage
    typedef struct packed {
        logic                     valid;
        logic                     cov;
        logic                     emit;
        logic                     last;
        logic                     row_end;
        logic [POS_W-1:0]         pos;
        logic [CH_W-1:0]          ch;
        logic signed [GRAD_W-1:0] grad;
    } t_tok;

    // one emitted sum on its way to the scaler
    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    last;
        logic                    row_end;
        logic [POS_W-1:0]        pos;
        logic [CH_W-1:0]         ch;
        logic signed [ACC_W-1:0] sum;
    } t_sum;

    typedef struct packed {
        logic              active;
        logic [ACC_AW-1:0] addr;
    } t_clr;

    function automatic logic [ACC_AW-1:0] slot_addr(logic [CH_W-1:0] ch,
                                                    logic [POS_W-1:0] pos);
        return {ch, pos[KAW-1:0]};
    endfunction

endpackage

// ===== hdl/apb_if.sv =====
interface apb_in_if import apb_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_in;

    modport source (output valid, output grad_in, input ready);
    modport sink   (input valid, input grad_in, output ready);
endinterface

interface apb_out_if import apb_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_out;
    logic [POS_W-1:0]         out_position;
    logic [CH_W-1:0]          out_channel;
    logic                     last_of_run;
    logic                     row_end;

    modport source (output valid, output grad_out, output out_position, output out_channel,
                    output last_of_run, output row_end, input ready);
    modport sink   (input valid, input grad_out, input out_position, input out_channel,
                    input last_of_run, input row_end, output ready);
endinterface

// ===== hdl/apb_ram.sv =====
module apb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/apb_ctrl.sv =====
module apb_ctrl import apb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    apb_in_if.sink                i_grad,
    input  logic                  i_adv,
    output logic [RECIP_W-1:0]    o_recip,
    output logic                  o_rd_en,
    output logic [ACC_AW-1:0]     o_rd_addr,
    output t_tok                  o_tok,
    output t_clr                  o_clr
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [ACC_AW-1:0] r_clr_cnt, n_clr_cnt;

    logic [CHN_W-1:0]   r_channels, n_channels;
    logic [RW_W-1:0]    r_row_width, n_row_width;
    logic [STR_W-1:0]   r_stride, n_stride;
    logic [KER_W-1:0]   r_kernel, n_kernel;
    logic [RECIP_W-1:0] r_recip, n_recip;
    logic               cfg_hit;

    logic [POS_W-1:0] r_win, n_win;
    logic [CH_W-1:0]  r_chan, n_chan;

    // item being walked
    logic signed [GRAD_W-1:0] r_grad;
    logic [CH_W-1:0]          r_ch;
    logic [RW_W-1:0]          r_p;
    logic [RW_W-1:0]          r_cov_end;
    logic [RW_W-1:0]          r_emit_end;
    logic [RW_W-1:0]          r_seq_end;
    logic                     r_row_done;

    t_tok r_tok, n_tok;

    logic [CHN_W-1:0] nch;
    logic [RW_W-1:0]  w;
    logic [STR_W-1:0] sx;
    logic [KER_W-1:0] k;

    logic             restart;
    logic [RW_W-1:0]  s13;
    logic [CH_W-1:0]  chv;
    logic [RW_W-1:0]  cov_end, emit_end, seq_end, cov_raw, emit_raw;
    logic [CHN_W-1:0] chan_inc;
    logic [RW_W-1:0]  next_win;
    logic             row_done;
    logic             accept;
    logic             run;

    // clamp the registers to their usable ranges
    always_comb begin
        if (r_channels == '0) nch = CHN_W'(1);
        else if (r_channels > CHN_W'(CHAN_MAX)) nch = CHN_W'(CHAN_MAX);
        else nch = r_channels;

        if (r_row_width == '0) w = RW_W'(1);
        else if (r_row_width > RW_W'(MAX_WIDTH)) w = RW_W'(MAX_WIDTH);
        else w = r_row_width;

        if (r_stride == '0) sx = STR_W'(1);
        else if (r_stride > STR_W'(MAX_STRIDE)) sx = STR_W'(MAX_STRIDE);
        else sx = r_stride;

        if (r_kernel < KER_W'(2)) k = KER_W'(2);
        else if (r_kernel > KER_W'(MAX_KERNEL)) k = KER_W'(MAX_KERNEL);
        else k = r_kernel;
    end

    assign accept         = i_grad.valid && i_grad.ready;
    assign i_grad.ready   = (r_state == ST_IDLE) && !r_tok.valid;
    assign run            = (r_state == ST_RUN);

    // window geometry of the item on the input channel
    always_comb begin
        restart  = ({1'b0, r_win} >= w) || ({1'b0, r_chan} >= nch);
        s13      = restart ? '0 : {1'b0, r_win};
        chv      = restart ? '0 : r_chan;
        cov_raw  = s13 + RW_W'(k);
        emit_raw = s13 + RW_W'(sx);
        cov_end  = (cov_raw > w) ? w : cov_raw;
        emit_end = (emit_raw > w) ? w : emit_raw;
        seq_end  = (cov_end > emit_end) ? cov_end : emit_end;
        chan_inc = {1'b0, chv} + CHN_W'(1);
        next_win = emit_raw;
        row_done = (chan_inc >= nch) && (next_win >= w);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_win       = r_win;
        n_chan      = r_chan;
        n_channels  = r_channels;
        n_row_width = r_row_width;
        n_stride    = r_stride;
        n_kernel    = r_kernel;
        n_recip     = r_recip;
        cfg_hit     = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS: begin
                    n_channels = i_cfg_data[CHN_W-1:0];
                    cfg_hit    = 1'b1;
                end
                CFG_ROW_WIDTH: begin
                    n_row_width = i_cfg_data[RW_W-1:0];
                    cfg_hit     = 1'b1;
                end
                CFG_STRIDE: begin
                    n_stride = i_cfg_data[STR_W-1:0];
                    cfg_hit  = 1'b1;
                end
                CFG_KERNEL: begin
                    n_kernel = i_cfg_data[KER_W-1:0];
                    cfg_hit  = 1'b1;
                end
                CFG_RECIP: begin
                    n_recip = i_cfg_data[RECIP_W-1:0];
                    cfg_hit = 1'b1;
                end
                default: ;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + ACC_AW'(1);
                if (r_clr_cnt == ACC_AW'(ACC_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    if (chan_inc >= nch) begin
                        n_chan = '0;
                        n_win  = row_done ? '0 : next_win[POS_W-1:0];
                    end else begin
                        n_chan = chan_inc[CH_W-1:0];
                        n_win  = s13[POS_W-1:0];
                    end
                end
            end
            ST_RUN: begin
                if (i_adv && (r_p + RW_W'(1) == r_seq_end)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase

        // any listed register write drops the row and wipes the store
        if (cfg_hit) begin
            n_state   = ST_CLEAR;
            n_clr_cnt = '0;
            n_win     = '0;
            n_chan    = '0;
        end
    end

    always_comb begin
        n_tok.valid   = run;
        n_tok.cov     = r_p < r_cov_end;
        n_tok.emit    = r_p < r_emit_end;
        n_tok.last    = (r_p + RW_W'(1)) == r_emit_end;
        n_tok.row_end = r_row_done && n_tok.last;
        n_tok.pos     = r_p[POS_W-1:0];
        n_tok.ch      = r_ch;
        n_tok.grad    = r_grad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_win       <= '0;
            r_chan      <= '0;
            r_channels  <= CHN_W'(1);
            r_row_width <= RW_W'(1);
            r_stride    <= STR_W'(1);
            r_kernel    <= KER_W'(2);
            r_recip     <= RECIP_RESET;
            r_tok       <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_win       <= n_win;
            r_chan      <= n_chan;
            r_channels  <= n_channels;
            r_row_width <= n_row_width;
            r_stride    <= n_stride;
            r_kernel    <= n_kernel;
            r_recip     <= n_recip;
            if (i_adv) begin
                r_tok <= n_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grad     <= i_grad.grad_in;
            r_ch       <= chv;
            r_p        <= s13;
            r_cov_end  <= cov_end;
            r_emit_end <= emit_end;
            r_seq_end  <= seq_end;
            r_row_done <= row_done;
        end else if (run && i_adv) begin
            r_p <= r_p + RW_W'(1);
        end
    end

    // read only covered positions; gap positions carry a zero
    assign o_rd_en    = run && i_adv && n_tok.cov;
    assign o_rd_addr  = slot_addr(r_ch, r_p[POS_W-1:0]);
    assign o_tok      = r_tok;
    assign o_clr      = '{active: (r_state == ST_CLEAR), addr: r_clr_cnt};
    assign o_recip    = r_recip;

endmodule

// ===== hdl/apb_accum.sv =====
module apb_accum import apb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_tok              i_tok,
    input  logic [ACC_W-1:0]  i_rdata,
    input  t_clr              i_clr,
    output logic              o_we,
    output logic [ACC_AW-1:0] o_waddr,
    output logic [ACC_W-1:0]  o_wdata,
    output t_sum              o_sum
);

    logic signed [ACC_W:0]   sum_wide;
    logic signed [ACC_W-1:0] sum_sat;
    t_sum                    r_sum;

    always_comb begin
        sum_wide = $signed({i_rdata[ACC_W-1], i_rdata})
                 + $signed({{(ACC_W + 1 - GRAD_W){i_tok.grad[GRAD_W-1]}}, i_tok.grad});
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                      : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    // clearing pass owns the write port; otherwise write back, zero once emitted
    always_comb begin
        if (i_clr.active) begin
            o_we    = 1'b1;
            o_waddr = i_clr.addr;
            o_wdata = '0;
        end else begin
            o_we    = i_adv && i_tok.valid && i_tok.cov;
            o_waddr = slot_addr(i_tok.ch, i_tok.pos);
            o_wdata = i_tok.emit ? '0 : sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_adv) begin
            r_sum.valid   <= i_tok.valid && i_tok.emit;
            r_sum.zero    <= !i_tok.cov;
            r_sum.last    <= i_tok.last;
            r_sum.row_end <= i_tok.row_end;
            r_sum.pos     <= i_tok.pos;
            r_sum.ch      <= i_tok.ch;
            r_sum.sum     <= sum_sat;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/apb_scale.sv =====
module apb_scale import apb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RECIP_W-1:0] i_recip,
    input  t_sum               i_sum,
    apb_out_if.source          o_grad,
    output logic               o_adv
);

    localparam int RQ_W = PROD_W - FRAC_W;

    logic                     adv;
    logic signed [PROD_W-1:0] mul;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r3_valid;
    logic                     r3_last;
    logic                     r3_row_end;
    logic [POS_W-1:0]         r3_pos;
    logic [CH_W-1:0]          r3_ch;

    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        mag_rnd;
    logic [RQ_W-1:0]          rq;
    logic signed [GRAD_W-1:0] q;

    logic                     r_out_valid;
    logic signed [GRAD_W-1:0] r_out_grad;
    logic [POS_W-1:0]         r_out_pos;
    logic [CH_W-1:0]          r_out_ch;
    logic                     r_out_last;
    logic                     r_out_row_end;

    assign adv   = !r_out_valid || o_grad.ready;
    assign o_adv = adv;

    // gap positions multiply a zero sum
    assign mul = $signed(i_sum.zero ? {ACC_W{1'b0}} : i_sum.sum) * $signed({1'b0, i_recip});

    // round half away from zero, then saturate to 32 bits
    always_comb begin
        neg     = r_prod[PROD_W-1];
        mag     = neg ? $unsigned(-r_prod) : $unsigned(r_prod);
        mag_rnd = mag + PROD_W'(1 << (FRAC_W - 1));
        rq      = mag_rnd[PROD_W-1:FRAC_W];
        if (!neg && rq > RQ_W'(32'h7FFF_FFFF)) begin
            q = {1'b0, {(GRAD_W - 1){1'b1}}};
        end else if (neg && rq > RQ_W'(33'h0_8000_0000)) begin
            q = {1'b1, {(GRAD_W - 1){1'b0}}};
        end else begin
            q = neg ? -$signed(rq[GRAD_W-1:0]) : $signed(rq[GRAD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r3_valid    <= i_sum.valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod        <= mul;
            r3_last       <= i_sum.last;
            r3_row_end    <= i_sum.row_end;
            r3_pos        <= i_sum.pos;
            r3_ch         <= i_sum.ch;
            r_out_grad    <= q;
            r_out_pos     <= r3_pos;
            r_out_ch      <= r3_ch;
            r_out_last    <= r3_last;
            r_out_row_end <= r3_row_end;
        end
    end

    assign o_grad.valid        = r_out_valid;
    assign o_grad.grad_out     = r_out_grad;
    assign o_grad.out_position = r_out_pos;
    assign o_grad.out_channel  = r_out_ch;
    assign o_grad.last_of_run  = r_out_last;
    assign o_grad.row_end      = r_out_row_end;

endmodule

// ===== hdl/avg_pool_1d_backward.sv =====
// Average pooling 1-D backward: unpools a stream of pooled gradients.
// Input channel i_grad carries one pooled gradient per beat, in row order
// (window by window, channel fastest). Output channel o_grad carries one
// unpooled gradient per beat with its position, channel, a last-of-item flag
// and a row-end flag. Each input beat yields 1 to stride output beats (fewer
// at the row end); positions in gaps between windows come out as zero.
// The input side walks up to max(kernel_size, stride) positions of one item,
// clipped at the row end, one position per cycle while the output is not
// stalled, through a read-modify-write of the accumulator RAM; the next beat
// is taken once the last write-back has landed. Each result passes through
// registered RAM read, accumulate, multiply and round/saturate steps in that
// order on its way to the output.
// After reset, and after any write to a listed register, a clearing pass
// zeroes all 1024 accumulators; no input beat is taken meanwhile, and a
// register write also restarts the row.
// When the receiver stalls, the whole position pipeline holds and the output
// beat stays put until taken.
module avg_pool_1d_backward import apb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    apb_in_if.sink                i_grad,
    apb_out_if.source             o_grad
);

    logic               adv;
    logic [RECIP_W-1:0] recip;
    logic               rd_en;
    logic [ACC_AW-1:0]  rd_addr;
    logic [ACC_W-1:0]   rdata;
    logic               we;
    logic [ACC_AW-1:0]  waddr;
    logic [ACC_W-1:0]   wdata;
    t_tok               tok;
    t_clr               clr;
    t_sum               sum;

    apb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_grad     (i_grad),
        .i_adv      (adv),
        .o_recip    (recip),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_tok      (tok),
        .o_clr      (clr)
    );

    apb_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    apb_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tok   (tok),
        .i_rdata (rdata),
        .i_clr   (clr),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_sum   (sum)
    );

    apb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_recip (recip),
        .i_sum   (sum),
        .o_grad  (o_grad),
        .o_adv   (adv)
    );

endmodule

// ===== hdl/apb_checker.sv =====
module apb_checker import apb_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_we,
    input logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [GRAD_W-1:0] i_grad_out,
    input logic [POS_W-1:0]         i_out_position,
    input logic [CH_W-1:0]          i_out_channel,
    input logic                     i_last_of_run,
    input logic                     i_row_end
);

    logic cfg_listed;

    assign cfg_listed = i_cfg_we && (i_cfg_idx == CFG_CHANNELS || i_cfg_idx == CFG_ROW_WIDTH ||
                                     i_cfg_idx == CFG_STRIDE || i_cfg_idx == CFG_KERNEL ||
                                     i_cfg_idx == CFG_RECIP);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_grad_out) &&
            $stable(i_out_position) && $stable(i_out_channel) &&
            $stable(i_last_of_run) && $stable(i_row_end))
        else $error("output beat changed while stalled");

    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_row_end |-> i_last_of_run)
        else $error("row end on a beat that is not the last of its item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while an item is still being walked");

    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_listed |=> !i_in_ready)
        else $error("input ready during the clearing pass");

endmodule

bind avg_pool_1d_backward apb_checker u_apb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_idx      (i_cfg_idx),
    .i_in_valid     (i_grad.valid),
    .i_in_ready     (i_grad.ready),
    .i_out_valid    (o_grad.valid),
    .i_out_ready    (o_grad.ready),
    .i_grad_out     (o_grad.grad_out),
    .i_out_position (o_grad.out_position),
    .i_out_channel  (o_grad.out_channel),
    .i_last_of_run  (o_grad.last_of_run),
    .i_row_end      (o_grad.row_end)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import apb_pkg::*;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad;
        logic [POS_W-1:0]         pos;
        logic [CH_W-1:0]          ch;
        logic                     last;
        logic                     row_end;
    } t_unpooled;

    localparam longint ACC_HI       = 64'sd34359738367;
    localparam longint ACC_LO       = -64'sd34359738368;
    localparam int     DRAIN_CYCLES = 40;

    localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = 32'sh80000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    apb_in_if  pooled ();
    apb_out_if unpooled ();

    avg_pool_1d_backward DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_grad     (pooled),
        .o_grad     (unpooled)
    );

    // mirror of the block's registers and accumulator ring
    logic [CHN_W-1:0]   m_channels;
    logic [RW_W-1:0]    m_width;
    logic [STR_W-1:0]   m_stride;
    logic [KER_W-1:0]   m_kernel;
    logic [RECIP_W-1:0] m_recip;
    longint             acc_mirror [ACC_DEPTH];
    int                 win_start;
    int                 chan_idx;

    t_unpooled unpooled_q [$];
    int        mismatches;
    bit        src_idle;
    bit        sink_idle;
    int        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // sum times Q0.16 scale, round half away from zero, saturate to 32 bits
    function automatic logic signed [GRAD_W-1:0] scale_round(longint sum);
        longint prod;
        longint q;
        prod = sum * longint'(m_recip);
        if (prod >= 0)
            q = (prod + 64'sd32768) >>> FRAC_W;
        else
            q = -((-prod + 64'sd32768) >>> FRAC_W);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[GRAD_W-1:0];
    endfunction

    function automatic logic signed [GRAD_W-1:0] rand_grad();
        case ($urandom_range(0, 7))
            0: return GRAD_MAX;
            1: return GRAD_MIN;
            2, 3: return GRAD_W'(int'($urandom_range(0, 131071)) - 65536);
            default: return GRAD_W'($urandom);
        endcase
    endfunction

    task automatic restart_row();
        foreach (acc_mirror[i]) acc_mirror[i] = 0;
        win_start = 0;
        chan_idx  = 0;
    endtask

    // add one pooled gradient into its window and queue the positions it closes
    task automatic unpool_step(input logic signed [GRAD_W-1:0] g);
        int        nch, w, sx, k, s, ch, cover_end, emit_end, slot;
        longint    sum;
        bit        row_done;
        t_unpooled r;
        nch = clip(int'(m_channels), 1, CHAN_MAX);
        w   = clip(int'(m_width), 1, MAX_WIDTH);
        sx  = clip(int'(m_stride), 1, MAX_STRIDE);
        k   = clip(int'(m_kernel), 2, MAX_KERNEL);
        row_done = 1'b0;
        if (win_start >= w || chan_idx >= nch) begin
            win_start = 0;
            chan_idx  = 0;
        end
        s = win_start;
        ch = chan_idx;
        cover_end = (s + k > w) ? w : s + k;
        for (int p = s; p < cover_end; p++) begin
            slot = ch * MAX_KERNEL + p % MAX_KERNEL;
            sum = acc_mirror[slot] + longint'(g);
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            acc_mirror[slot] = sum;
        end
        chan_idx = ch + 1;
        if (chan_idx >= nch) begin
            chan_idx = 0;
            win_start = s + sx;
            if (win_start >= w) begin
                win_start = 0;
                row_done = 1'b1;
            end
        end
        emit_end = (s + sx > w) ? w : s + sx;
        for (int p = s; p < emit_end; p++) begin
            r.grad = '0;
            if (p < s + k) begin
                slot = ch * MAX_KERNEL + p % MAX_KERNEL;
                r.grad = scale_round(acc_mirror[slot]);
                acc_mirror[slot] = 0;
            end
            r.pos     = POS_W'(p);
            r.ch      = CH_W'(ch);
            r.last    = (p + 1 == emit_end);
            r.row_end = row_done && (p + 1 == emit_end);
            unpooled_q.push_back(r);
        end
    endtask

    task automatic drain_unpooled();
        while (unpooled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_pool(input logic [CFG_DATA_W-1:0] chans, width, strd,
                                input logic [CFG_DATA_W-1:0] kern, recip);
        drain_unpooled();
        write_reg(CFG_CHANNELS, chans);
        write_reg(CFG_ROW_WIDTH, width);
        write_reg(CFG_STRIDE, strd);
        write_reg(CFG_KERNEL, kern);
        write_reg(CFG_RECIP, recip);
        // an index past the register list must change nothing
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_RECIP) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        m_channels = chans[CHN_W-1:0];
        m_width    = width[RW_W-1:0];
        m_stride   = strd[STR_W-1:0];
        m_kernel   = kern[KER_W-1:0];
        m_recip    = recip[RECIP_W-1:0];
        restart_row();
    endtask

    // leave valid high when the next beat follows at once
    task automatic send_grad(input logic signed [GRAD_W-1:0] g);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            pooled.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pooled.valid   <= 1'b1;
        pooled.grad_in <= g;
        do @(posedge i_clk); while (!pooled.ready);
        unpool_step(g);
    endtask

    task automatic finish_burst();
        pooled.valid <= 1'b0;
        drain_unpooled();
    endtask

    task automatic test_reset_defaults();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        send_grad(GRAD_MAX);
        send_grad(GRAD_MIN);
        send_grad(1);
        send_grad(-1);
        finish_burst();
    endtask

    task automatic test_overlap_clip();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        program_pool(2, 5, 1, 3, 21845);
        for (int i = 0; i < 10; i++)
            send_grad((i % 3 == 0) ? GRAD_MAX : (i % 3 == 1) ? GRAD_MIN : GRAD_W'(i * 12345));
        finish_burst();
    endtask

    task automatic test_stride_gaps();
        program_pool(1, 12, 8, 2, 32768);
        send_grad(3);
        send_grad(-3);
        finish_burst();
    endtask

    task automatic test_output_saturation();
        program_pool(1, 20, 1, 16, 16'hFFFF);
        repeat (2) send_grad(GRAD_MAX);
        repeat (4) send_grad(GRAD_MIN);
        finish_burst();
    endtask

    task automatic test_clamped_registers();
        program_pool(16'hFFFF, 16'hFFFF, 15, 31, 0);
        send_grad(GRAD_MAX);
        send_grad(GRAD_MIN);
        finish_burst();
        program_pool(0, 0, 0, 1, 16'hFFFF);
        send_grad(GRAD_MAX);
        finish_burst();
    endtask

    task automatic test_channel_sweep();
        program_pool(CHAN_MAX, 2, 2, 3, 21845);
        repeat (70) send_grad(rand_grad());
        finish_burst();
    endtask

    task automatic test_wide_row();
        program_pool(1, MAX_WIDTH, MAX_STRIDE, MAX_KERNEL, 4096);
        repeat (40) send_grad(rand_grad());
        finish_burst();
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        program_pool(1, 64, MAX_STRIDE, MAX_KERNEL, 4096);
        hold_req = 400;
        repeat (12) send_grad(rand_grad());
        finish_burst();
    endtask

    task automatic test_random_rows(input int budget);
        int nch, w, sx, k, n_items;
        logic [CFG_DATA_W-1:0] recip;
        while (budget > 0) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // raw register values, out of range ones included
                program_pool(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom));
                n_items = $urandom_range(10, 30);
            end else begin
                nch = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
                w   = $urandom_range(1, 40);
                sx  = $urandom_range(1, MAX_STRIDE);
                k   = $urandom_range(2, MAX_KERNEL);
                recip = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                    : CFG_DATA_W'((65536 + k / 2) / k);
                program_pool(nch, w, sx, k, recip);
                n_items = ((w + sx - 1) / sx) * nch * $urandom_range(1, 3)
                          + $urandom_range(0, nch);
                if (n_items > 60) n_items = 60;
            end
            repeat (n_items) send_grad(rand_grad());
            finish_burst();
            budget -= n_items;
        end
    endtask

    initial begin : result_sink
        int gap;
        unpooled.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = sink_idle ? $urandom_range(0, 4) : 0;
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end
            if (gap > 0) begin
                unpooled.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            unpooled.ready <= 1'b1;
            do @(posedge i_clk); while (!unpooled.valid);
        end
    end

    task automatic compare_field(input string name, input logic [GRAD_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_beat
        t_unpooled want;
        if (i_rst_n && unpooled.valid && unpooled.ready) begin
            if (unpooled_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got pos %0d ch %0d grad %0h",
                         $time, unpooled.out_position, unpooled.out_channel,
                         unpooled.grad_out);
                mismatches++;
            end else begin
                want = unpooled_q.pop_front();
                compare_field("grad_out", want.grad, unpooled.grad_out);
                compare_field("out_position", GRAD_W'(want.pos), GRAD_W'(unpooled.out_position));
                compare_field("out_channel", GRAD_W'(want.ch), GRAD_W'(unpooled.out_channel));
                compare_field("last_of_run", GRAD_W'(want.last), GRAD_W'(unpooled.last_of_run));
                compare_field("row_end", GRAD_W'(want.row_end), GRAD_W'(unpooled.row_end));
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_CHANNELS;
        i_cfg_data     <= '0;
        pooled.valid   <= 1'b0;
        pooled.grad_in <= '0;
        src_idle   = 1'b0;
        sink_idle  = 1'b0;
        hold_req   = 0;
        mismatches = 0;
        m_channels = 1;
        m_width    = 1;
        m_stride   = 1;
        m_kernel   = 2;
        m_recip    = RECIP_RESET;
        restart_row();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_overlap_clip();
        test_stride_gaps();
        test_output_saturation();
        test_clamped_registers();
        test_channel_sweep();
        test_wide_row();
        test_backpressure();
        test_random_rows(250);

        drain_unpooled();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/apb_pkg.sv
hdl/apb_if.sv
hdl/apb_ram.sv
hdl/apb_ctrl.sv
hdl/apb_accum.sv
hdl/apb_scale.sv
hdl/avg_pool_1d_backward.sv
hdl/apb_checker.sv
dv/testbench.sv
